/* rtl/ddr_pkg.sv */
// shared types and constants for the decimal digit reversal pipeline
`default_nettype none

package ddr_pkg;

   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned REV_W      = 35;
   localparam int unsigned COUNT_W    = 4;

   // fixed-point reciprocal of ten, exact for every 32-bit dividend with a shift of 35
   localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
   localparam int unsigned        RECIP10_SHIFT = 35;

   // input register, two registers per digit, output register
   localparam int unsigned LATENCY = 2 * MAX_DIGITS + 2;

   // one item in flight between digit stages
   typedef struct packed {
      logic                   valid;
      logic                   negative;
      logic [VALUE_W-1:0]     mag;
      logic [REV_W-1:0]       rev;
      logic [COUNT_W-1:0]     count;
   } lane_type;

endpackage

`default_nettype wire

/* rtl/ddr_digit_stage.sv */
// one decimal digit step: divide by ten, then fold the remainder into the reversed value
`default_nettype none

module ddr_digit_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ddr_pkg::lane_type lane_i,
   output ddr_pkg::lane_type      lane_o
);
   import ddr_pkg::*;

   localparam int unsigned PROD_W = 2 * VALUE_W;
   localparam int unsigned Q_W    = PROD_W - RECIP10_SHIFT;

   // first half: quotient by reciprocal multiply
   logic [PROD_W-1:0]  prod;
   lane_type           a_ff;
   logic [Q_W-1:0]     q_ff;
   logic [Q_W-1:0]     q_in;

   // second half: remainder, accumulate
   logic [VALUE_W-1:0] q_ext;
   logic [VALUE_W-1:0] q_times10;
   logic [VALUE_W-1:0] rem_full;
   logic [3:0]         digit;
   logic [REV_W-1:0]   rev_times10;
   lane_type           b_in;
   lane_type           b_ff;

   assign prod = {{VALUE_W{1'b0}}, lane_i.mag} * {{VALUE_W{1'b0}}, RECIP10};
   assign q_in = prod[PROD_W-1:RECIP10_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else begin
         a_ff <= lane_i;
      end
      q_ff <= q_in;
   end

   assign q_ext       = VALUE_W'(q_ff);
   assign q_times10   = (q_ext << 3) + (q_ext << 1);
   assign rem_full    = a_ff.mag - q_times10;
   assign digit       = rem_full[3:0];
   assign rev_times10 = (a_ff.rev << 3) + (a_ff.rev << 1);

   always_comb begin
      b_in = a_ff;
      // digits stop once the magnitude runs out
      if (a_ff.mag != '0) begin
         b_in.mag   = q_ext;
         b_in.rev   = rev_times10 + REV_W'(digit);
         b_in.count = a_ff.count + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else begin
         b_ff <= b_in;
      end
   end

   assign lane_o = b_ff;

endmodule

`default_nettype wire

/* rtl/decimal_digit_reverse.sv */
// top level: pipelined reversal of the decimal digits of a signed integer
`default_nettype none

// Reverses the decimal digits of the magnitude of a signed 32-bit request and
// reapplies the sign; leading zeros of the reversed number drop away (120 gives
// 21, -120 gives -21) and the result is exact in 35 bits, also for the most
// negative input. digit_count is the number of significant digits, zero for a
// zero request. The block takes one request every cycle and busy never rises.
// Between a request and its result lie one input register, two registers per
// digit over ten digit stages (reciprocal multiply, then remainder and
// accumulate), and one output register for the sign. The result strobe
// rsp_valid is high for exactly one cycle per request, in request order; the
// receiver cannot stall it, so it must take every result as it comes.
module decimal_digit_reverse (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic signed [ddr_pkg::VALUE_W-1:0] req_value,
   output      logic                          rsp_valid,
   output      logic signed [ddr_pkg::REV_W-1:0]   rsp_reversed,
   output      logic [ddr_pkg::COUNT_W-1:0]   rsp_digit_count
);
   import ddr_pkg::*;

   // input register: sign and magnitude split off
   lane_type         in_in;
   lane_type         in_ff;
   // lanes between digit stages
   lane_type         lane [0:MAX_DIGITS];
   // output register
   logic             out_valid_ff;
   logic [REV_W-1:0] out_rev_ff;
   logic [REV_W-1:0] out_rev_in;
   logic [COUNT_W-1:0] out_count_ff;
   lane_type         last;

   // never stalls: every cycle has room for a new request
   assign busy = 1'b0;

   always_comb begin
      in_in          = '0;
      in_in.valid    = start && !busy;
      in_in.negative = req_value[VALUE_W-1];
      // unsigned negate covers the most negative value as well
      in_in.mag      = req_value[VALUE_W-1] ? (~req_value + VALUE_W'(1)) : req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid <= 1'b0;
      end else begin
         in_ff <= in_in;
      end
   end

   assign lane[0] = in_ff;

   // one stage per decimal digit
   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_digit
      ddr_digit_stage u_stage (
         .clock  (clock),
         .reset  (reset),
         .lane_i (lane[g]),
         .lane_o (lane[g+1])
      );
   end

   assign last       = lane[MAX_DIGITS];
   assign out_rev_in = last.negative ? (~last.rev + REV_W'(1)) : last.rev;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= last.valid;
      end
      out_rev_ff   <= out_rev_in;
      out_count_ff <= last.count;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_reversed    = out_rev_ff;
   assign rsp_digit_count = out_count_ff;

`ifndef NO_ASSERTIONS
   // a result strobe only follows a matching earlier request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result strobe without matching request");

   // zero digits exactly when the reversed value is zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_count == '0) == (rsp_reversed == '0)))
      else $error("digit count and reversed value disagree on zero");

   // digit count never exceeds the digit stages
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_count <= COUNT_W'(MAX_DIGITS)))
      else $error("digit count out of range");

   // a taken request always enters the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> in_ff.valid)
      else $error("request lost at pipeline entry");
`endif

endmodule

`default_nettype wire

/* tb/sv/decimal_digit_reverse_tb.sv */
// self-checking testbench for the decimal digit reversal block
`default_nettype none

module decimal_digit_reverse_tb;
   import ddr_pkg::*;

   // decimal base of the reversal and largest positive request magnitude
   localparam int unsigned      DEC_BASE       = 10;
   localparam longint unsigned  MAX_POS_MAG    = 64'd2147483647;
   // cycles with neither a request nor a result taken before the run is abandoned
   localparam int unsigned      WATCHDOG_LIMIT = 1000;
   // random requests, and how often the sender waits for the pipe to empty
   localparam int unsigned      RANDOM_REQUESTS = 1350;
   localparam int unsigned      DRAIN_EVERY     = 400;
   // length of a stretch of back-to-back requests and of a stretch with gaps
   localparam int unsigned      STRETCH_LEN     = 150;

   // one predicted result
   typedef struct packed {
      logic signed [REV_W-1:0] reversed;
      logic [COUNT_W-1:0]      digit_count;
   } digit_result_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [VALUE_W-1:0]    req_value;
   logic                         rsp_valid;
   logic signed [REV_W-1:0]      rsp_reversed;
   logic [COUNT_W-1:0]           rsp_digit_count;

   // predicted results, oldest first, in request order
   digit_result_type             awaited_reversals[$];
   digit_result_type             oldest_expected;

   int unsigned                  requests_sent;
   int unsigned                  results_checked;
   int unsigned                  mismatch_count;
   int unsigned                  stall_cycles;
   int unsigned                  drains_done;

   decimal_digit_reverse u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_reversed    (rsp_reversed),
      .rsp_digit_count (rsp_digit_count)
   );

   // free-running clock, period 20
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // exact reversal of the low MAX_DIGITS digits of the magnitude; the most
   // negative request has magnitude 2^31, which still fits 32 unsigned bits
   function automatic digit_result_type reverse_digits(input logic signed [VALUE_W-1:0] value);
      digit_result_type        res;
      logic [VALUE_W-1:0]      mag;
      logic [63:0]             acc;
      int unsigned             n;
      mag = value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
      acc = '0;
      n   = 0;
      // peel digits off the low end, pushing each onto the accumulator
      while (n < MAX_DIGITS && mag != 0) begin
         acc = acc * DEC_BASE + 64'(mag % DEC_BASE);
         mag = mag / DEC_BASE;
         n++;
      end
      // sign of the request goes back onto the reversed magnitude
      if (value[VALUE_W-1]) begin
         acc = -acc;
      end
      res.reversed    = acc[REV_W-1:0];
      res.digit_count = n[COUNT_W-1:0];
      return res;
   endfunction

   function automatic longint unsigned power_of_ten(input int unsigned k);
      longint unsigned p;
      p = 1;
      repeat (k) p = p * DEC_BASE;
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------

   // hold the request until the edge that takes it, then record the prediction;
   // start stays high on return so back-to-back requests never drop it
   task automatic send_request(input logic signed [VALUE_W-1:0] value);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      awaited_reversals.push_back(reverse_digits(value));
      requests_sent++;
   endtask

   // idle gap: start low, noise on the data port since it is ignored
   task automatic idle_for(input int unsigned cycles);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) begin
            req_value <= $urandom;
            @(posedge clock);
         end
      end
   endtask

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   task automatic send_with_gap(input logic signed [VALUE_W-1:0] value);
      send_request(value);
      idle_for(pick_gap());
   endtask

   // stop sending until every outstanding result has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (awaited_reversals.size() != 0) @(posedge clock);
      drains_done++;
   endtask

   // ---------------------------------------------------------------------
   // result checking: the receiver cannot stall, so every strobe is taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_reversals.size() == 0) begin
            $display("%0t: result with nothing outstanding: reversed %0d count %0d",
                     $time, rsp_reversed, rsp_digit_count);
            mismatch_count++;
         end else begin
            oldest_expected = awaited_reversals.pop_front();
            results_checked++;
            if (rsp_reversed !== oldest_expected.reversed) begin
               $display("%0t: reversed mismatch: expected %0d actual %0d",
                        $time, oldest_expected.reversed, rsp_reversed);
               mismatch_count++;
            end
            if (rsp_digit_count !== oldest_expected.digit_count) begin
               $display("%0t: digit_count mismatch: expected %0d actual %0d",
                        $time, oldest_expected.digit_count, rsp_digit_count);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: any taken request or result restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding",
                  $time, awaited_reversals.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // zero gives zero digits; single digits reverse to themselves with sign kept
   task automatic test_zero_and_units();
      send_with_gap(32'sd0);
      send_with_gap(32'sd1);
      send_with_gap(-32'sd1);
      send_with_gap(32'sd9);
      send_with_gap(-32'sd9);
   endtask

   // trailing zeros of the request become leading zeros and drop away
   task automatic test_trailing_zeros();
      send_with_gap(32'sd10);
      send_with_gap(32'sd120);
      send_with_gap(-32'sd120);
      send_with_gap(32'sd1000000000);
   endtask

   // range ends, the most negative value, and reversals wider than 32 bits
   task automatic test_extremes();
      send_with_gap(32'sh7FFF_FFFF);
      send_with_gap(-32'sh7FFF_FFFF);
      send_with_gap(32'sh8000_0000);
      send_with_gap(32'sd1999999999);
      send_with_gap(-32'sd1000000009);
   endtask

   // all-nines of lengths two to nine, so each of those digit counts shows up
   task automatic test_digit_lengths();
      int unsigned k;
      for (k = 2; k <= 9; k++) begin
         send_with_gap(VALUE_W'(power_of_ten(k) - 1));
      end
   endtask

   // random magnitudes of every length, trailing zeros, values near the ends
   task automatic test_random_values();
      int unsigned            i;
      int unsigned            k;
      int unsigned            z;
      longint unsigned        lo;
      longint unsigned        hi;
      longint unsigned        mag;
      logic signed [VALUE_W-1:0] value;
      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         case ($urandom_range(9, 0))
            0, 1, 2: begin
               // raw pattern, every bit toggles
               value = $urandom;
            end
            3, 4, 5, 6: begin
               // chosen digit length, uniform inside it
               k     = $urandom_range(MAX_DIGITS, 1);
               lo    = power_of_ten(k - 1);
               hi    = (k == MAX_DIGITS) ? MAX_POS_MAG : power_of_ten(k) - 1;
               mag   = $urandom_range(hi[31:0], lo[31:0]);
               value = $urandom_range(1, 0) ? -VALUE_W'(mag) : VALUE_W'(mag);
            end
            7: begin
               // random head followed by a run of zeros
               z     = $urandom_range(8, 1);
               hi    = MAX_POS_MAG / power_of_ten(z);
               mag   = longint'($urandom_range(hi[31:0], 1)) * power_of_ten(z);
               value = $urandom_range(1, 0) ? -VALUE_W'(mag) : VALUE_W'(mag);
            end
            8: begin
               // close to the top positive or most negative value
               value = $urandom_range(1, 0) ? 32'sh7FFF_FFFF - $urandom_range(20, 0)
                                            : 32'sh8000_0000 + $urandom_range(20, 0);
            end
            default: begin
               // small values, zero included
               mag   = $urandom_range(99, 0);
               value = $urandom_range(1, 0) ? -VALUE_W'(mag) : VALUE_W'(mag);
            end
         endcase
         send_request(value);
         // alternate stretches of back-to-back requests and stretches with gaps
         if ((i / STRETCH_LEN) % 3 != 1) begin
            idle_for(pick_gap());
         end
         // hold off now and then until the pipe is empty
         if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            wait_for_drain();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_value       = '0;
      requests_sent   = 0;
      results_checked = 0;
      mismatch_count  = 0;
      stall_cycles    = 0;
      drains_done     = 0;

      // synchronous reset held high, then released
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_zero_and_units();
      test_trailing_zeros();
      test_extremes();
      test_digit_lengths();
      wait_for_drain();
      test_random_values();

      // everything sent: wait for the last results, then keep clocking so a stray strobe is caught
      start <= 1'b0;
      while (awaited_reversals.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      $display("run covered %0d requests and %0d checked results, %0d pipe drains",
               requests_sent, results_checked, drains_done);
      $display("zero, sign, trailing zeros, range ends and every digit length were driven");
      if (mismatch_count == 0 && awaited_reversals.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
